[rtl/mhrc_pkg.sv]
// Shared constants and types for the meeting-room counter.
// No dependencies; the other files of the block, but for mhrc_heap_ram, refer to it by scoped name.
`default_nettype none

package mhrc_pkg;

  localparam int unsigned HEAP_DEPTH_DEF = 64;
  localparam int unsigned TIME_WIDTH_DEF = 32;
  localparam int unsigned ROOMS_W        = 7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_UP,
    ST_DOWN,
    ST_WRV,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

[rtl/mhrc_if.sv]
// Valid/ready channel interfaces for interval beats in and room-count beats out.
// Depends on mhrc_pkg for default widths.
`default_nettype none

interface mhrc_in_if #(
  parameter int unsigned TIME_WIDTH = mhrc_pkg::TIME_WIDTH_DEF
);
  logic                  valid;
  logic                  ready;
  logic [TIME_WIDTH-1:0] start_time;
  logic [TIME_WIDTH-1:0] end_time;
  logic                  new_set;

  modport source (output valid, output start_time, output end_time, output new_set,
                  input ready);
  modport sink (input valid, input start_time, input end_time, input new_set,
                output ready);
endinterface

interface mhrc_out_if;
  logic                           valid;
  logic                           ready;
  logic [mhrc_pkg::ROOMS_W-1:0]   rooms_in_use;
  logic                           overflow;
  logic                           order_error;

  modport source (output valid, output rooms_in_use, output overflow, output order_error,
                  input ready);
  modport sink (input valid, input rooms_in_use, input overflow, input order_error,
                output ready);
endinterface

`default_nettype wire

[rtl/mhrc_heap_ram.sv]
// Heap store: one write port, two registered read ports, no reset.
// Depends on nothing but its parameters.
`default_nettype none

module mhrc_heap_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_a_i,
  input  wire logic [AW-1:0]    raddr_b_i,
  output logic      [WIDTH-1:0] rdata_a_o,
  output logic      [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

`default_nettype wire

[rtl/mhrc_ctrl.sv]
// Sift sequencer: root test, sift up / sift down over the heap store, result register.
// Depends on mhrc_pkg and the channel interfaces in mhrc_if.sv.
`default_nettype none

module mhrc_ctrl #(
  parameter int unsigned HEAP_DEPTH = mhrc_pkg::HEAP_DEPTH_DEF,
  parameter int unsigned TIME_WIDTH = mhrc_pkg::TIME_WIDTH_DEF,
  localparam int unsigned IDX_W     = $clog2(HEAP_DEPTH),
  localparam int unsigned CNT_W     = $clog2(HEAP_DEPTH + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  mhrc_in_if.sink                    in_i,
  mhrc_out_if.source                 out_o,
  output logic                       mem_we_o,
  output logic      [IDX_W-1:0]      mem_waddr_o,
  output logic      [TIME_WIDTH-1:0] mem_wdata_o,
  output logic      [IDX_W-1:0]      mem_raddr_a_o,
  output logic      [IDX_W-1:0]      mem_raddr_b_o,
  input  wire logic [TIME_WIDTH-1:0] mem_rdata_a_i,
  input  wire logic [TIME_WIDTH-1:0] mem_rdata_b_i
);

  localparam int unsigned W2 = IDX_W + 2;
  localparam int unsigned RW = mhrc_pkg::ROOMS_W;

  mhrc_pkg::state_e state_q, state_d;

  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [TIME_WIDTH-1:0] prev_q, prev_d;
  logic                  out_valid_q, out_valid_d;

  logic [TIME_WIDTH-1:0] v_q, v_d;
  logic [TIME_WIDTH-1:0] start_q, start_d;
  logic [IDX_W-1:0]      pos_q, pos_d;
  logic                  ord_q, ord_d;
  logic                  ovf_q, ovf_d;
  logic [RW-1:0]         rooms_q;
  logic                  ovf_out_q, ord_out_q;

  logic                  accept;
  logic                  load_out;
  logic [IDX_W-1:0]      par, gpar;
  logic [W2-1:0]         cnt_w, lft, rgt, child_w, nl;
  logic                  take_l, take_r;
  logic [TIME_WIDTH-1:0] best_val;
  logic [CNT_W+RW-1:0]   cnt_ext;

  assign accept  = in_i.valid & in_i.ready;
  assign cnt_w   = W2'(cnt_q);
  assign par     = (pos_q - IDX_W'(1)) >> 1;
  assign gpar    = (par - IDX_W'(1)) >> 1;
  assign lft     = (W2'(pos_q) << 1) + W2'(1);
  assign rgt     = lft + W2'(1);
  assign take_l  = mem_rdata_a_i < v_q;
  assign best_val = take_l ? mem_rdata_a_i : v_q;
  assign take_r  = (rgt < cnt_w) && (mem_rdata_b_i < best_val);
  assign child_w = take_r ? rgt : lft;
  assign nl      = (child_w << 1) + W2'(1);
  assign cnt_ext = {{RW{1'b0}}, cnt_q};

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    prev_d        = prev_q;
    v_d           = v_q;
    start_d       = start_q;
    pos_d         = pos_q;
    ord_d         = ord_q;
    ovf_d         = ovf_q;
    in_i.ready    = 1'b0;
    load_out      = 1'b0;
    mem_we_o      = 1'b0;
    mem_waddr_o   = pos_q;
    mem_wdata_o   = v_q;
    mem_raddr_a_o = '0;
    mem_raddr_b_o = '0;

    case (state_q)
      mhrc_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (accept) begin
          v_d     = in_i.end_time;
          start_d = in_i.start_time;
          prev_d  = in_i.start_time;
          ord_d   = ~in_i.new_set & (in_i.start_time < prev_q);
          if (in_i.new_set) begin
            cnt_d = '0;
          end
          state_d = mhrc_pkg::ST_DECIDE;
        end
      end
      mhrc_pkg::ST_DECIDE: begin
        ovf_d = 1'b0;
        if (cnt_q != '0 && mem_rdata_a_i <= start_q) begin
          pos_d = '0;
          if (cnt_q > CNT_W'(1)) begin
            mem_raddr_a_o = IDX_W'(1);
            mem_raddr_b_o = IDX_W'(2);
            state_d       = mhrc_pkg::ST_DOWN;
          end else begin
            mem_we_o    = 1'b1;
            mem_waddr_o = '0;
            state_d     = mhrc_pkg::ST_EMIT;
          end
        end else if (cnt_q < CNT_W'(HEAP_DEPTH)) begin
          cnt_d = cnt_q + CNT_W'(1);
          if (cnt_q == '0) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = '0;
            state_d     = mhrc_pkg::ST_EMIT;
          end else begin
            pos_d         = cnt_q[IDX_W-1:0];
            mem_raddr_a_o = IDX_W'((cnt_q - CNT_W'(1)) >> 1);
            state_d       = mhrc_pkg::ST_UP;
          end
        end else begin
          ovf_d   = 1'b1;
          state_d = mhrc_pkg::ST_EMIT;
        end
      end
      mhrc_pkg::ST_UP: begin
        mem_we_o = 1'b1;
        if (mem_rdata_a_i > v_q) begin
          mem_wdata_o = mem_rdata_a_i;
          pos_d       = par;
          if (par == '0) begin
            state_d = mhrc_pkg::ST_WRV;
          end else begin
            mem_raddr_a_o = gpar;
          end
        end else begin
          state_d = mhrc_pkg::ST_EMIT;
        end
      end
      mhrc_pkg::ST_DOWN: begin
        mem_we_o = 1'b1;
        if (take_l || take_r) begin
          mem_wdata_o = take_r ? mem_rdata_b_i : mem_rdata_a_i;
          pos_d       = child_w[IDX_W-1:0];
          if (nl < cnt_w) begin
            mem_raddr_a_o = nl[IDX_W-1:0];
            mem_raddr_b_o = nl[IDX_W-1:0] + IDX_W'(1);
          end else begin
            state_d = mhrc_pkg::ST_WRV;
          end
        end else begin
          state_d = mhrc_pkg::ST_EMIT;
        end
      end
      mhrc_pkg::ST_WRV: begin
        mem_we_o = 1'b1;
        state_d  = mhrc_pkg::ST_EMIT;
      end
      mhrc_pkg::ST_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = mhrc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mhrc_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = load_out | (out_valid_q & ~out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mhrc_pkg::ST_IDLE;
      cnt_q       <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      prev_q      <= prev_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q     <= v_d;
    start_q <= start_d;
    pos_q   <= pos_d;
    ord_q   <= ord_d;
    ovf_q   <= ovf_d;
    if (load_out) begin
      rooms_q   <= cnt_ext[RW-1:0];
      ovf_out_q <= ovf_q;
      ord_out_q <= ord_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.rooms_in_use = rooms_q;
  assign out_o.overflow     = ovf_out_q;
  assign out_o.order_error  = ord_out_q;

endmodule

`default_nettype wire

[rtl/min_heap_room_counter_top.sv]
// Meeting-room counter: min-heap of end times held in a synchronous RAM.
// Depends on mhrc_pkg, mhrc_if.sv, mhrc_heap_ram and mhrc_ctrl.
//
// Usage:
//   in_i carries one interval per beat (start_time, end_time, new_set), starts
//   presorted in nondecreasing order; new_set marks the first interval of a set.
//   out_o returns one beat per interval: rooms_in_use after it, overflow when an
//   insert hit a full heap, order_error when the start went backwards.
//   Steps: accept, root test, one heap level of the sift per step (sift down
//   reads both children at once on the two RAM read ports), a final write and
//   the result load; an overflow goes from the root test to the result load.
//   One interval is worked on at a time; in_i.ready is high only while the
//   sequencer is idle.
//   The result sits in an output register, so the next interval is taken while
//   a result still waits; a stalled receiver holds that beat and the following
//   result waits in the sequencer until the register frees.
//   Reset clears the room count, the previous start and the output valid; the
//   RAM is not cleared and needs no sweep.
`default_nettype none

module min_heap_room_counter_top #(
  parameter int unsigned HEAP_DEPTH = mhrc_pkg::HEAP_DEPTH_DEF,
  parameter int unsigned TIME_WIDTH = mhrc_pkg::TIME_WIDTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mhrc_in_if.sink    in_i,
  mhrc_out_if.source out_o
);

  localparam int unsigned IDX_W = $clog2(HEAP_DEPTH);

  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [TIME_WIDTH-1:0] mem_wdata;
  logic [IDX_W-1:0]      mem_raddr_a;
  logic [IDX_W-1:0]      mem_raddr_b;
  logic [TIME_WIDTH-1:0] mem_rdata_a;
  logic [TIME_WIDTH-1:0] mem_rdata_b;

  mhrc_heap_ram #(
    .DEPTH (HEAP_DEPTH),
    .WIDTH (TIME_WIDTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (mem_rdata_a),
    .rdata_b_o (mem_rdata_b)
  );

  mhrc_ctrl #(
    .HEAP_DEPTH (HEAP_DEPTH),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .out_o         (out_o),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_a_o (mem_raddr_a),
    .mem_raddr_b_o (mem_raddr_b),
    .mem_rdata_a_i (mem_rdata_a),
    .mem_rdata_b_i (mem_rdata_b)
  );

endmodule

`default_nettype wire
